[rtl/vital_sign_alert_monitor_core_assert.svh]
// Assertion macros for the vital sign alert monitor checker.
// Included by the checker file only.
`ifndef VITAL_SIGN_ALERT_MONITOR_CORE_ASSERT_SVH
`define VITAL_SIGN_ALERT_MONITOR_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define VSAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VSAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/vsam_pkg.sv]
// Shared types, constants and event codes for the vital sign alert monitor.
// No dependencies.
package vsam_pkg;
  localparam int unsigned WindowDepthDef = 8;
  localparam int unsigned NumCfg = 8;

  typedef enum logic [3:0] {
    EV_PRES_ON = 4'd0, EV_PRES_OFF = 4'd1,
    EV_BR_NONE = 4'd2, EV_BR_LOW = 4'd3, EV_BR_HIGH = 4'd4, EV_BR_IRREG = 4'd5,
    EV_HR_NONE = 4'd6, EV_HR_LOW = 4'd7, EV_HR_HIGH = 4'd8,
    EV_LIGHT = 4'd9, EV_DARK = 4'd10
  } event_e;

  typedef enum logic [2:0] {
    CFG_BR_LOW = 3'd0, CFG_BR_HIGH = 3'd1, CFG_BR_SD = 3'd2, CFG_HR_LOW = 3'd3,
    CFG_HR_HIGH = 3'd4, CFG_ZERO_HOLD = 3'd5, CFG_LIMIT_HOLD = 3'd6,
    CFG_LIGHT_TH = 3'd7
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_ACC, ST_VAR, ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input, evaluate rate alerts, write window
    logic acc_clr;   // clear sums
    logic acc_step;  // add one window entry
    logic var_done;  // compare variance, set irregular bit
    logic emit_next; // advance event pointer
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc_last;  // last entry being summed
    logic win_full;  // window full after this write
    logic present;   // tick has presence
    logic ev_any;    // an event is pending
    logic ev_last;   // pending event is the final one
  } sts_t;
endpackage

[rtl/vsam_ctrl.sv]
// Sequencer for the vital sign alert monitor: walks evaluate, sum, compare
// and emit steps. Depends on vsam_pkg.
module vsam_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  vsam_pkg::sts_t sts_i,
  output vsam_pkg::cmd_t cmd_o
);
  import vsam_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.acc_clr = 1'b1;
        if (sts_i.present && sts_i.win_full) state_d = ST_ACC;
        else state_d = ST_EMIT;
      end
      ST_ACC: begin
        cmd_o.acc_step = 1'b1;
        if (sts_i.acc_last) state_d = ST_VAR;
      end
      ST_VAR: begin
        cmd_o.var_done = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.ev_any) begin
          state_d = ST_IDLE;
        end else begin
          out_valid_o = 1'b1;
          if (!out_stall_i) begin
            cmd_o.emit_next = 1'b1;
            if (sts_i.ev_last) state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

[rtl/vsam_dp.sv]
// Datapath for the vital sign alert monitor: registers, hold timers,
// breath window, variance sums and event selection. Depends on vsam_pkg.
module vsam_dp #(
  parameter int unsigned WindowDepth = vsam_pkg::WindowDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  input  logic [31:0]    time_ms_i,
  input  logic [11:0]    breath_rate_i,
  input  logic [11:0]    heart_rate_i,
  input  logic           target_detected_i,
  input  logic [15:0]    lux_i,
  input  vsam_pkg::cmd_t cmd_i,
  output vsam_pkg::sts_t sts_o,
  output logic [3:0]     event_code_o,
  output logic [15:0]    event_value_o,
  output logic           last_event_o
);
  import vsam_pkg::*;

  localparam int unsigned IdxW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned FillW = $clog2(WindowDepth + 1);
  localparam int unsigned SxW = 12 + IdxW + 1;
  localparam int unsigned SxxW = 24 + IdxW + 1;
  localparam int unsigned VarW = SxxW + FillW + 2;
  localparam logic [FillW-1:0] FullFill = FillW'(WindowDepth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WindowDepth - 1);
  localparam logic [15:0] NN1 = 16'(WindowDepth * (WindowDepth - 1));

  // configuration registers
  logic [7:0]  br_low_q, br_high_q, br_sd_q, hr_low_q, hr_high_q;
  logic [31:0] zero_hold_q, limit_hold_q;
  logic [15:0] light_th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_low_q <= 8'd10; br_high_q <= 8'd20; br_sd_q <= 8'd48;
      hr_low_q <= 8'd40; hr_high_q <= 8'd100;
      zero_hold_q <= 32'd10000; limit_hold_q <= 32'd5000; light_th_q <= 16'd50;
    end else if (cfg_valid_i && cfg_ready_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_BR_LOW:     br_low_q <= cfg_data_i[7:0];
        CFG_BR_HIGH:    br_high_q <= cfg_data_i[7:0];
        CFG_BR_SD:      br_sd_q <= cfg_data_i[7:0];
        CFG_HR_LOW:     hr_low_q <= cfg_data_i[7:0];
        CFG_HR_HIGH:    hr_high_q <= cfg_data_i[7:0];
        CFG_ZERO_HOLD:  zero_hold_q <= cfg_data_i;
        CFG_LIMIT_HOLD: limit_hold_q <= cfg_data_i;
        CFG_LIGHT_TH:   light_th_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // rate conditions for the incoming tick
  logic presence;
  logic [5:0] cond;
  logic [31:0] hold_len [6];
  assign presence = target_detected_i || (breath_rate_i != '0) || (heart_rate_i != '0);
  assign cond[0] = breath_rate_i == '0;
  assign cond[1] = (breath_rate_i != '0) && ({4'd0, breath_rate_i[11:4]} < {4'd0, br_low_q});
  assign cond[2] = breath_rate_i[11:4] > br_high_q;
  assign cond[3] = heart_rate_i == '0;
  assign cond[4] = (heart_rate_i != '0) && (heart_rate_i[11:4] < hr_low_q);
  assign cond[5] = heart_rate_i[11:4] > hr_high_q;
  assign hold_len[0] = zero_hold_q;
  assign hold_len[1] = limit_hold_q;
  assign hold_len[2] = limit_hold_q;
  assign hold_len[3] = zero_hold_q;
  assign hold_len[4] = limit_hold_q;
  assign hold_len[5] = limit_hold_q;

  // per-tick state
  logic [31:0] start_q [6];
  logic [6:0]  alert_q, alert_prev_q;
  logic        pres_prev_q, light_prev_q;
  logic [IdxW-1:0]  widx_q, ridx_q;
  logic [FillW-1:0] fill_q;
  logic [11:0] win_q [WindowDepth];
  logic [7:0]  br_int_q, hr_int_q;
  logic [15:0] lux_q;
  logic [10:0] ev_pend_q;  // one bit per event code
  logic        present_q;

  // variance sums
  logic [SxW-1:0]  sx_q;
  logic [SxxW-1:0] sxx_q;
  logic [SxxW-1:0] sxx_all;
  logic [23:0]     sq_q;   // registered square of previous entry
  logic            sq_v_q;
  logic [VarW-1:0] lhs, rhs;
  logic [15:0]     sd2;
  logic            irreg;

  logic [6:0] alert_new;
  logic [10:0] ev_load;
  logic light_now, pres_ev, light_ev;
  always_comb begin
    alert_new = {alert_q[6:4], alert_q[3], alert_q[2:0]};
    for (int k = 0; k < 6; k++) begin
      logic [31:0] st;
      st = (start_q[k] == '0) ? time_ms_i : start_q[k];
      alert_new[(k < 3) ? k : k + 1] = cond[k] && ((time_ms_i - st) >= hold_len[k]);
    end
  end
  assign light_now = lux_i >= light_th_q;

  // presence and light edges seen at capture
  always_comb begin
    ev_load = '0;
    ev_load[EV_PRES_ON] = presence && !pres_prev_q;
    ev_load[EV_PRES_OFF] = !presence && pres_prev_q;
    ev_load[EV_LIGHT] = light_now && !light_prev_q;
    ev_load[EV_DARK] = !light_now && light_prev_q;
  end

  // variance compare, last square still in sq_q during the compare cycle
  assign sxx_all = sxx_q + SxxW'(sq_q);
  assign sd2 = br_sd_q * br_sd_q;
  assign lhs = VarW'(sxx_all) * VarW'(WindowDepth) - VarW'(sx_q) * VarW'(sx_q);
  assign rhs = VarW'(sd2) * VarW'(NN1);
  assign irreg = lhs > rhs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) start_q[k] <= '0;
      alert_q <= '0; alert_prev_q <= '0; pres_prev_q <= 1'b0; light_prev_q <= 1'b0;
      widx_q <= '0; fill_q <= '0; ev_pend_q <= '0; present_q <= 1'b0;
      ridx_q <= '0; sq_v_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        present_q <= presence;
        pres_prev_q <= presence;
        light_prev_q <= light_now;
        ev_pend_q <= ev_load;
        if (!presence) begin
          for (int k = 0; k < 6; k++) start_q[k] <= '0;
          alert_q <= '0; alert_prev_q <= '0; widx_q <= '0; fill_q <= '0;
        end else begin
          for (int k = 0; k < 6; k++)
            start_q[k] <= !cond[k] ? '0 : ((start_q[k] == '0) ? time_ms_i : start_q[k]);
          alert_q <= alert_new;
          widx_q <= (widx_q == LastIdx) ? '0 : widx_q + 1'b1;
          if (fill_q != FullFill) fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.acc_clr) begin
        ridx_q <= '0; sq_v_q <= 1'b0;
      end
      if (cmd_i.acc_step) begin
        ridx_q <= (ridx_q == LastIdx) ? '0 : ridx_q + 1'b1;
        sq_v_q <= 1'b1;
      end
      if (cmd_i.var_done) alert_q[3] <= irreg;
      // after evaluation, latch alert edges into pending events
      if ((cmd_i.acc_clr && !(present_q && sts_o.win_full)) || cmd_i.var_done) begin
        logic [6:0] a;
        a = cmd_i.var_done ? {alert_q[6:4], irreg, alert_q[2:0]} : alert_q;
        if (present_q) begin
          ev_pend_q[8:2] <= a ^ alert_prev_q;
          alert_prev_q <= a;
        end
      end
      if (cmd_i.emit_next) ev_pend_q <= ev_pend_q & (ev_pend_q - 1'b1);
    end
  end

  // payload registers: window, sums, captured values
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      br_int_q <= breath_rate_i[11:4];
      hr_int_q <= heart_rate_i[11:4];
      lux_q <= lux_i;
      if (presence) win_q[widx_q] <= breath_rate_i;
    end
    if (cmd_i.acc_clr) begin
      sx_q <= '0; sxx_q <= '0;
    end
    if (cmd_i.acc_step) begin
      sx_q <= sx_q + SxW'(win_q[ridx_q]);
      sq_q <= win_q[ridx_q] * win_q[ridx_q];
      if (sq_v_q) sxx_q <= sxx_q + SxxW'(sq_q);
    end
    if (cmd_i.var_done) sxx_q <= sxx_all;
  end

  // lowest pending event goes out first
  logic [3:0] ev_code;
  always_comb begin
    ev_code = EV_PRES_ON;
    for (int k = 10; k >= 0; k--) if (ev_pend_q[k]) ev_code = 4'(k);
  end

  assign sts_o.acc_last = ridx_q == LastIdx;
  assign sts_o.win_full = fill_q == FullFill;
  assign sts_o.present = present_q;
  assign sts_o.ev_any = ev_pend_q != '0;
  assign sts_o.ev_last = (ev_pend_q & (ev_pend_q - 1'b1)) == '0;

  assign event_code_o = ev_code;
  assign last_event_o = sts_o.ev_last;
  always_comb begin
    unique case (event_e'(ev_code))
      EV_BR_NONE, EV_BR_LOW, EV_BR_HIGH, EV_BR_IRREG: event_value_o = {8'd0, br_int_q};
      EV_HR_NONE, EV_HR_LOW, EV_HR_HIGH: event_value_o = {8'd0, hr_int_q};
      EV_LIGHT, EV_DARK: event_value_o = lux_q;
      default: event_value_o = '0;
    endcase
  end
endmodule

[rtl/vital_sign_alert_monitor_core.sv]
// The first event is shown in the emit state, reached through the evaluate state, and
// also through the sum and compare states when a target is present and the window is full.
// A new request is taken only in the idle state, after every pending event has been shown
// or after the emit state finds none; output stalls hold the emit state.
// Reset (rst_ni low, asynchronous) restores default thresholds and clears
// presence, light, alerts, hold timers and window fill.
module vital_sign_alert_monitor_core #(
  parameter int unsigned WindowDepth = vsam_pkg::WindowDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] time_ms_i,
  input  logic [11:0] breath_rate_i,
  input  logic [11:0] heart_rate_i,
  input  logic        target_detected_i,
  input  logic [15:0] lux_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_code_o,
  output logic [15:0] event_value_o,
  output logic        last_event_o
);
  import vsam_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  vsam_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  vsam_dp #(.WindowDepth(WindowDepth)) u_dp (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .time_ms_i, .breath_rate_i, .heart_rate_i, .target_detected_i,
    .lux_i, .cmd_i(cmd), .sts_o(sts), .event_code_o, .event_value_o, .last_event_o
  );
endmodule

[rtl/vsam_checker.sv]
// Port-level checker for the vital sign alert monitor, bound to the top.
// Depends on vital_sign_alert_monitor_core_assert.svh.
`include "vital_sign_alert_monitor_core_assert.svh"
module vsam_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  event_code_o,
  input logic        last_event_o
);
  // no new request while events are shown
  `VSAM_ASSERT_IMP(a_no_accept_emit, clk_i, rst_ni, out_valid_o, in_stall_o)
  // codes stay in range
  `VSAM_ASSERT_IMP(a_code_range, clk_i, rst_ni, out_valid_o, event_code_o <= 4'd10)
  // after an accepted request, no event appears in the next cycle
  `VSAM_ASSERT_NXT(a_gap, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o)
  // stalled event holds
  `VSAM_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(event_code_o) && $stable(last_event_o))
endmodule

bind vital_sign_alert_monitor_core vsam_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .event_code_o, .last_event_o
);
